>>> sv/sldd_pkg.sv
package sldd_pkg;

   localparam int BYTE_W  = 8;
   localparam int HDR_W   = 4;
   localparam int WIDTH_W = 8;
   localparam int COUNT_W = 12;
   localparam int LINE_W  = 8;
   localparam int CHAR_W  = 6;
   localparam int DIST_W  = 3 * CHAR_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;

   localparam logic [BYTE_W-1:0] LINE_END    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_OFFSET = 8'h30;
   localparam logic [LINE_W-1:0] COUNT_MAX   = 8'hFF;
   localparam logic [1:0]        GROUP_LAST  = 2'd2;

   localparam logic [HDR_W-1:0]   HEADER_LINES_RST = 4'd3;
   localparam logic [WIDTH_W-1:0] LINE_WIDTH_RST   = 8'd64;
   localparam logic [COUNT_W-1:0] VALUE_LIMIT_RST  = 12'd682;
   localparam logic [LINE_W-1:0]  MIN_LINES_RST    = 8'd5;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_HEADER_LINES = 2'd0,
      REG_LINE_WIDTH   = 2'd1,
      REG_VALUE_LIMIT  = 2'd2,
      REG_MIN_LINES    = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [HDR_W-1:0]   header_lines;
      logic [WIDTH_W-1:0] line_width;
      logic [COUNT_W-1:0] value_limit;
      logic [LINE_W-1:0]  min_lines;
   } cfg_type;

   typedef struct packed {
      logic [DIST_W-1:0]  distance;
      logic [COUNT_W-1:0] value_index;
      logic               scan_end;
   } result_type;

endpackage

>>> sv/sldd_req_if.sv
interface sldd_req_if;
   logic                          valid;
   logic                          ready;
   logic [sldd_pkg::BYTE_W-1:0]   rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> sv/sldd_rsp_if.sv
interface sldd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sldd_pkg::DIST_W-1:0]   distance;
   logic [sldd_pkg::COUNT_W-1:0]  value_index;
   logic                          scan_end;

   modport source (output valid, output distance, output value_index, output scan_end,
                   input ready);
   modport sink   (input valid, input distance, input value_index, input scan_end,
                   output ready);
endinterface

>>> sv/sldd_csr.sv
module sldd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [sldd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sldd_pkg::CSR_DATA_W-1:0]   csr_data,
   output sldd_pkg::cfg_type                 cfg
);
   import sldd_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_HEADER_LINES: cfg_in.header_lines = csr_data[HDR_W-1:0];
            REG_LINE_WIDTH:   cfg_in.line_width   = csr_data[WIDTH_W-1:0];
            REG_VALUE_LIMIT:  cfg_in.value_limit  = csr_data[COUNT_W-1:0];
            REG_MIN_LINES:    cfg_in.min_lines    = csr_data[LINE_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_lines <= HEADER_LINES_RST;
         cfg_ff.line_width   <= LINE_WIDTH_RST;
         cfg_ff.value_limit  <= VALUE_LIMIT_RST;
         cfg_ff.min_lines    <= MIN_LINES_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule

>>> sv/sldd_in_reg.sv
module sldd_in_reg (
   input  logic                          clock,
   input  logic                          reset,
   sldd_req_if.sink                      req_chan,
   input  logic                          take,
   output logic                          byte_valid,
   output logic [sldd_pkg::BYTE_W-1:0]   byte_data
);
   import sldd_pkg::*;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] data_ff, data_in;
   logic              load;

   // stage refills in the same cycle it is consumed
   assign req_chan.ready = !valid_ff || take;
   assign load = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = req_chan.rx_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;
endmodule

>>> sv/sldd_decode.sv
module sldd_decode (
   input  logic                          clock,
   input  logic                          reset,
   input  sldd_pkg::cfg_type             cfg,
   input  logic                          byte_valid,
   input  logic [sldd_pkg::BYTE_W-1:0]   byte_data,
   input  logic                          out_free,
   output logic                          take,
   output logic                          emit,
   output sldd_pkg::result_type          result
);
   import sldd_pkg::*;

   logic [LINE_W-1:0]   line_ff, line_in;
   logic [WIDTH_W-1:0]  col_ff, col_in;
   logic [1:0]          group_ff, group_in;
   logic [2*CHAR_W-1:0] partial_ff, partial_in;
   logic [COUNT_W-1:0]  emitted_ff, emitted_in;

   logic              is_end;
   logic              end_scan;
   logic              keep;
   logic [BYTE_W-1:0] shifted;
   logic [CHAR_W-1:0] char_bits;

   assign take      = byte_valid && out_free;
   assign is_end    = byte_data == LINE_END;
   assign end_scan  = is_end && col_ff == '0 && line_ff > cfg.min_lines;
   assign keep      = !is_end
                      && line_ff >= {{(LINE_W-HDR_W){1'b0}}, cfg.header_lines}
                      && col_ff < cfg.line_width
                      && emitted_ff < cfg.value_limit;
   assign shifted   = byte_data - CHAR_OFFSET;
   assign char_bits = shifted[CHAR_W-1:0];

   assign emit = take && (end_scan || (keep && group_ff == GROUP_LAST));

   always_comb begin
      result.scan_end    = end_scan;
      result.value_index = emitted_ff;
      result.distance    = end_scan ? '0 : {partial_ff, char_bits};
   end

   always_comb begin
      line_in    = line_ff;
      col_in     = col_ff;
      group_in   = group_ff;
      partial_in = partial_ff;
      emitted_in = emitted_ff;
      if (take) begin
         if (end_scan) begin
            line_in    = '0;
            col_in     = '0;
            group_in   = '0;
            partial_in = '0;
            emitted_in = '0;
         end else if (is_end) begin
            if (line_ff != COUNT_MAX) line_in = line_ff + 1'b1;
            col_in = '0;
         end else begin
            if (col_ff != COUNT_MAX) col_in = col_ff + 1'b1;
            if (keep) begin
               if (group_ff == GROUP_LAST) begin
                  group_in   = '0;
                  partial_in = '0;
                  emitted_in = emitted_ff + 1'b1;
               end else begin
                  group_in   = group_ff + 1'b1;
                  partial_in = {partial_ff[CHAR_W-1:0], char_bits};
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff    <= '0;
         col_ff     <= '0;
         group_ff   <= '0;
         partial_ff <= '0;
         emitted_ff <= '0;
      end else begin
         line_ff    <= line_in;
         col_ff     <= col_in;
         group_ff   <= group_in;
         partial_ff <= partial_in;
         emitted_ff <= emitted_in;
      end
   end
endmodule

>>> sv/sldd_out_reg.sv
module sldd_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  sldd_pkg::result_type   result,
   output logic                   out_free,
   sldd_rsp_if.source             rsp_chan
);
   import sldd_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   assign out_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_chan.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.distance    = data_ff.distance;
   assign rsp_chan.value_index = data_ff.value_index;
   assign rsp_chan.scan_end    = data_ff.scan_end;
endmodule

>>> sv/scan_line_deframe_and_decode.sv
// A byte is held in the input register, then its result is captured in the
// result register, which drives the response channel.
// Throughput: one byte per cycle while results are taken; the line, column
// and group counters update as each byte is taken, so bytes stream back to back.
// Reset: synchronous; registers return to their defaults, scan state clears.
module scan_line_deframe_and_decode (
   input  logic                              clock,
   input  logic                              reset,
   sldd_req_if.sink                          req_chan,
   sldd_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  logic [sldd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sldd_pkg::CSR_DATA_W-1:0]   csr_data
);
   import sldd_pkg::*;

   cfg_type           cfg;
   logic              take;
   logic              emit;
   logic              out_free;
   logic              byte_valid;
   logic [BYTE_W-1:0] byte_data;
   result_type        result;

   sldd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sldd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .take       (take),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   sldd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .byte_valid (byte_valid),
      .byte_data  (byte_data),
      .out_free   (out_free),
      .take       (take),
      .emit       (emit),
      .result     (result)
   );

   sldd_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (emit),
      .result   (result),
      .out_free (out_free),
      .rsp_chan (rsp_chan)
   );
endmodule

>>> sim/scan_line_deframe_and_decode_tb.sv
module scan_line_deframe_and_decode_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sldd_pkg::*;

   localparam int RANDOM_ITEMS = 800;
   localparam int QUIET_TAIL   = 150;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 4;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    csr_we;
   reg_index_type           csr_index;
   logic [CSR_DATA_W-1:0]   csr_data;

   sldd_req_if req_chan ();
   sldd_rsp_if rsp_chan ();

   scan_line_deframe_and_decode i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5ns clock = ~clock;

   // decoder shadow state
   cfg_type               model_cfg;
   logic [LINE_W-1:0]     line_cnt;
   logic [LINE_W-1:0]     col_cnt;
   logic [1:0]            grp_pos;
   logic [COUNT_W-1:0]    partial_bits;
   logic [COUNT_W-1:0]    emitted_cnt;
   result_type            pending_distances[$];

   bit  bursts_on = 1'b1;
   int  fail_count = 0;
   int  bytes_sent = 0;
   int  distances_seen = 0;
   int  scan_ends_seen = 0;
   int  configs_used = 0;
   int  cycle_count = 0;

   function automatic void clear_scan_state();
      line_cnt     = '0;
      col_cnt      = '0;
      grp_pos      = '0;
      partial_bits = '0;
      emitted_cnt  = '0;
   endfunction

   function automatic void decode_byte(input logic [BYTE_W-1:0] b);
      logic             keep;
      logic [BYTE_W-1:0] diff;
      logic [CHAR_W-1:0] c;
      result_type       r;
      if (b == LINE_END) begin
         if (col_cnt == 0 && line_cnt > model_cfg.min_lines) begin
            r.distance    = '0;
            r.value_index = emitted_cnt;
            r.scan_end    = 1'b1;
            pending_distances.push_back(r);
            clear_scan_state();
         end else begin
            if (line_cnt != COUNT_MAX) line_cnt++;
            col_cnt = '0;
         end
      end else begin
         keep = line_cnt >= model_cfg.header_lines && col_cnt < model_cfg.line_width &&
                emitted_cnt < model_cfg.value_limit;
         if (col_cnt != COUNT_MAX) col_cnt++;
         if (keep) begin
            // low six bits only, so bytes below the offset wrap instead of sign-extending
            diff = b - CHAR_OFFSET;
            c    = diff[CHAR_W-1:0];
            if (grp_pos != GROUP_LAST) begin
               partial_bits = {partial_bits[CHAR_W-1:0], c};
               grp_pos++;
            end else begin
               r.distance    = {partial_bits, c};
               r.value_index = emitted_cnt;
               r.scan_end    = 1'b0;
               pending_distances.push_back(r);
               emitted_cnt++;
               grp_pos      = '0;
               partial_bits = '0;
            end
         end
      end
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      if (bursts_on && $urandom_range(0, 7) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      decode_byte(b);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (pending_distances.size() != 0) @(posedge clock);
      // bytes that make no result may still be in the pipe
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic [HDR_W-1:0] hdr, input logic [WIDTH_W-1:0] width,
                            input logic [COUNT_W-1:0] limit, input logic [LINE_W-1:0] min_l);
      drain();
      csr_we    <= 1'b1;
      csr_index <= REG_HEADER_LINES;
      csr_data  <= CSR_DATA_W'(hdr);
      @(posedge clock);
      csr_index <= REG_LINE_WIDTH;
      csr_data  <= CSR_DATA_W'(width);
      @(posedge clock);
      csr_index <= REG_VALUE_LIMIT;
      csr_data  <= limit;
      @(posedge clock);
      csr_index <= REG_MIN_LINES;
      csr_data  <= CSR_DATA_W'(min_l);
      @(posedge clock);
      csr_we <= 1'b0;
      model_cfg.header_lines = hdr;
      model_cfg.line_width   = width;
      model_cfg.value_limit  = limit;
      model_cfg.min_lines    = min_l;
      configs_used++;
   endtask

   function automatic logic [BYTE_W-1:0] random_char();
      logic [BYTE_W-1:0] b;
      if ($urandom_range(0, 19) < 17) begin
         b = BYTE_W'($urandom_range(8'h30, 8'h6F));
      end else begin
         b = BYTE_W'($urandom_range(0, 255));
         if (b == LINE_END) b = 8'h0D;
      end
      return b;
   endfunction

   // defaults after reset: three header lines, min line count five
   task automatic test_reset_defaults();
      send_byte(LINE_END);
      send_byte(LINE_END);
      send_byte(LINE_END);
      send_text("abc");
      send_byte(LINE_END);
      repeat (3) send_byte(LINE_END);
   endtask

   // extreme and invalid characters, line width cut, one header line
   task automatic test_char_decode();
      configure(4'd1, 8'd9, 12'd4095, 8'd0);
      send_byte("H");
      send_byte(LINE_END);
      send_text("000ooo");
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h0D);
      send_text("AB");
      send_byte(LINE_END);
      send_byte(LINE_END);
   endtask

   task automatic test_register_extremes();
      // zero width drops every data character; an early empty line only counts
      configure(4'd0, 8'd0, 12'd1, 8'd1);
      send_text("abc");
      send_byte(LINE_END);
      send_byte(LINE_END);
      send_byte(LINE_END);
      // zero limit decodes nothing
      configure(4'd0, 8'd255, 12'd0, 8'd0);
      send_text("abc");
      send_byte(LINE_END);
      send_byte(LINE_END);
      // limit reached mid-line, then a scan with an unfinished group
      configure(4'd0, 8'd255, 12'd1, 8'd0);
      send_text("abcdef");
      send_byte(LINE_END);
      send_byte(LINE_END);
      send_text("ab");
      send_byte(LINE_END);
      send_byte(LINE_END);
   endtask

   // line count saturates; with min 255 an empty line never ends the scan
   task automatic test_line_count_saturation();
      configure(4'd15, 8'd255, 12'd4095, 8'd255);
      send_byte("z");
      repeat (300) send_byte(LINE_END);
      send_text("abc");
      send_byte(LINE_END);
      configure(4'd15, 8'd255, 12'd4095, 8'd254);
      send_byte(LINE_END);
   endtask

   task automatic random_scan();
      int n_lines;
      int len;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 20)) send_byte(BYTE_W'($urandom_range(0, 255)));
         return;
      end
      repeat (model_cfg.header_lines) begin
         repeat ($urandom_range(1, 6)) send_byte(random_char());
         send_byte(LINE_END);
      end
      n_lines = (model_cfg.line_width > 40) ? $urandom_range(1, 2) : $urandom_range(1, 5);
      repeat (n_lines) begin
         if (model_cfg.line_width > 40) len = $urandom_range(1, model_cfg.line_width);
         else len = model_cfg.line_width + $urandom_range(0, 3);
         if (len == 0) len = 1;
         repeat (len) send_byte(random_char());
         send_byte(LINE_END);
      end
      while (line_cnt <= model_cfg.min_lines && line_cnt != COUNT_MAX) send_byte(LINE_END);
      send_byte(LINE_END);
   endtask

   task automatic test_random_scans();
      int                 first;
      logic [HDR_W-1:0]   hdr;
      logic [WIDTH_W-1:0] width;
      logic [COUNT_W-1:0] limit;
      logic [LINE_W-1:0]  min_l;
      first = bytes_sent;
      while (bytes_sent - first < RANDOM_ITEMS) begin
         bursts_on = (bytes_sent - first) < RANDOM_ITEMS - QUIET_TAIL;
         case ($urandom_range(0, 5))
            0:       hdr = 4'd0;
            1:       hdr = 4'd15;
            2:       hdr = HDR_W'($urandom_range(0, 15));
            default: hdr = HDR_W'($urandom_range(0, 3));
         endcase
         case ($urandom_range(0, 7))
            0:       width = 8'd1;
            1:       width = 8'd255;
            2:       width = WIDTH_W'($urandom_range(0, 255));
            default: width = WIDTH_W'($urandom_range(1, 12));
         endcase
         case ($urandom_range(0, 7))
            0:       limit = 12'd1;
            1:       limit = 12'd4095;
            2:       limit = COUNT_W'($urandom_range(0, 4095));
            default: limit = COUNT_W'($urandom_range(1, 40));
         endcase
         case ($urandom_range(0, 9))
            0:       min_l = 8'd0;
            1:       min_l = LINE_W'($urandom_range(0, 255));
            default: min_l = LINE_W'($urandom_range(0, 6));
         endcase
         configure(hdr, width, limit, min_l);
         repeat ($urandom_range(1, 3)) random_scan();
      end
   endtask

   // result side stalls in bursts
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (bursts_on && !reset && $urandom_range(0, 7) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0h actual %0h", $realtime, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_distances.size() == 0) begin
            $display("%0t: no item expected, actual distance %0h index %0h end %0b", $realtime,
                     rsp_chan.distance, rsp_chan.value_index, rsp_chan.scan_end);
            fail_count++;
         end else begin
            want = pending_distances.pop_front();
            check_field("distance", want.distance, rsp_chan.distance);
            check_field("value_index", want.value_index, rsp_chan.value_index);
            check_field("scan_end", want.scan_end, rsp_chan.scan_end);
            if (want.scan_end) scan_ends_seen++;
            else distances_seen++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d items still expected", $realtime, pending_distances.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      reset            <= 1'b1;
      csr_we           <= 1'b0;
      csr_index        <= REG_HEADER_LINES;
      csr_data         <= '0;
      req_chan.valid   <= 1'b0;
      req_chan.rx_byte <= '0;
      model_cfg.header_lines = HEADER_LINES_RST;
      model_cfg.line_width   = LINE_WIDTH_RST;
      model_cfg.value_limit  = VALUE_LIMIT_RST;
      model_cfg.min_lines    = MIN_LINES_RST;
      clear_scan_state();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_char_decode();
      test_register_extremes();
      test_line_count_saturation();
      test_random_scans();

      drain();
      repeat (8) @(posedge clock);
      $display("Sent %0d bytes over %0d register settings", bytes_sent, configs_used);
      $display("Checked %0d distances and %0d scan ends", distances_seen, scan_ends_seen);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
